// ===== hdl/trle_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// trle_pkg : shared types and constants of the run-length encoder
// Command format between front and back end, byte marks, field widths and
// the back-end sequencer states.
// ============================================================================
package trle_pkg;

   localparam int LEN_W       = 7;    // run length field of a header byte
   localparam int PIX_W       = 8;    // palette index / output byte width
   localparam int CAP_W       = 24;   // capacity and byte counter width
   localparam int SUM_W       = 9;    // bytes caused by one pixel, worst case
   localparam int CNT_W       = 3;    // byte_count field
   localparam int RSP_BYTES   = 4;    // bytes per result
   localparam int RSP_DATA_W  = 40;   // four bytes + count, padded to bytes
   localparam int RSP_USER_W  = 2;
   localparam int CMD_DEPTH   = 2;    // command queue entries

   localparam logic [PIX_W-1:0] MARK_TRANSPARENT = 8'h80;
   localparam logic [PIX_W-1:0] MARK_OPAQUE      = 8'h00;
   localparam logic [PIX_W-1:0] LINE_CLOSE       = 8'h00;

   localparam logic ACT_PIXEL   = 1'b0;
   localparam logic ACT_RESTART = 1'b1;

   // one run to be written out by the back end
   typedef struct packed {
      logic             valid;
      logic             tr;      // transparent run: header byte only
      logic [LEN_W-1:0] len;
      logic             bank;    // literal store bank holding the pixels
   } run_desc_type;

   // everything one input pixel causes, in output order
   typedef struct packed {
      run_desc_type run_a;   // run closed before this pixel
      run_desc_type run_b;   // run closed by the line end
      logic         zero;    // line closing byte
      logic         ovf;     // overflow state after the pixel
   } cmd_type;

   // back end done reading a literal bank
   typedef struct packed {
      logic valid;
      logic bank;
   } bank_free_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_HDR,
      SQ_DAT,
      SQ_ZERO,
      SQ_EMPTY
   } seq_state_type;

endpackage

// ===== hdl/trle_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// trle_ram : simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
module trle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/trle_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// trle_cmd_fifo : command queue between front and back end
// Small register FIFO of per-pixel commands.
// ============================================================================
module trle_cmd_fifo import trle_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   cmd_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full    = (fill_ff == FILL_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/trle_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// trle_front : pixel classifier
// Tracks the open run and the output budget, stores literal pixels and
// decides per pixel which runs and closing bytes go out.
// ============================================================================
module trle_front import trle_pkg::*; #(
   parameter int RUN_LIMIT = 127
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CAP_W-1:0]       csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIX_W-1:0]       req_tdata,
   input  logic                   req_tuser,
   input  logic                   req_tlast,
   output logic                   cmd_push,
   output cmd_type                cmd,
   input  logic                   cmd_full,
   input  bank_free_type          free,
   output logic                   mem_we,
   output logic [IDX_W:0]         mem_waddr,
   output logic [PIX_W-1:0]       mem_wdata
);

   localparam int IDX_W = (RUN_LIMIT > 1) ? $clog2(RUN_LIMIT) : 1;
   localparam logic [LEN_W-1:0] LIMIT = LEN_W'(RUN_LIMIT);

   function automatic logic fits(input logic [CAP_W:0] room, input logic [SUM_W-1:0] need);
      fits = !room[CAP_W] && (room[CAP_W-1:0] >= CAP_W'(need));
   endfunction

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CAP_W-1:0] bytes_ff, bytes_in;
   logic [CAP_W:0]   room_ff, room_in;     // cap - bytes, two's complement
   logic [LEN_W-1:0] run_len_ff, run_len_in;
   logic             run_tr_ff, run_tr_in;
   logic             bank_ff, bank_in;
   logic             ovf_ff, ovf_in;
   logic [1:0]       busy_ff, busy_in;

   logic             accept, is_pixel, tr, brk, newrun, live;
   logic             a_ok, ovf_a, b_ok, z_ok, ovf_new, emits, stall;
   logic [SUM_W-1:0] size_a, used_a, size_b, need_b, need_z, total;
   logic [LEN_W-1:0] len1;
   logic             tr1, bank1;

   always_comb begin
      is_pixel = (req_tuser == ACT_PIXEL);
      tr       = (req_tdata == '0);
      brk      = (run_len_ff != '0) && ((tr != run_tr_ff) || (run_len_ff >= LIMIT));

      size_a = run_tr_ff ? SUM_W'(1) : SUM_W'(run_len_ff) + SUM_W'(1);
      a_ok   = !ovf_ff && brk && fits(room_ff, size_a);
      ovf_a  = !ovf_ff && brk && !fits(room_ff, size_a);
      used_a = a_ok ? size_a : '0;
      live   = !ovf_ff && !ovf_a;

      newrun = brk || (run_len_ff == '0);
      len1   = newrun ? LEN_W'(1) : run_len_ff + 1'b1;
      tr1    = newrun ? tr : run_tr_ff;
      bank1  = newrun ? !bank_ff : bank_ff;

      // line end: pending run including this pixel, then the closing byte
      size_b  = tr1 ? SUM_W'(1) : SUM_W'(len1) + SUM_W'(1);
      need_b  = used_a + size_b;
      need_z  = need_b + SUM_W'(1);
      b_ok    = live && req_tlast && fits(room_ff, need_b);
      z_ok    = b_ok && fits(room_ff, need_z);
      ovf_new = ovf_ff || ovf_a || (live && req_tlast && !z_ok);
      total   = z_ok ? need_z : (b_ok ? need_b : used_a);
      emits   = a_ok || b_ok || ovf_new;

      // a new literal run must not overwrite a bank still being read out
      stall      = is_pixel && !ovf_ff && newrun && !tr && busy_ff[bank1];
      req_tready = !cmd_full && !stall;
      accept     = req_tvalid && req_tready;
   end

   always_comb begin
      cmd.run_a.valid = a_ok;
      cmd.run_a.tr    = run_tr_ff;
      cmd.run_a.len   = run_len_ff;
      cmd.run_a.bank  = bank_ff;
      cmd.run_b.valid = b_ok;
      cmd.run_b.tr    = tr1;
      cmd.run_b.len   = len1;
      cmd.run_b.bank  = bank1;
      cmd.zero        = z_ok;
      cmd.ovf         = ovf_new;
      cmd_push        = accept && is_pixel && emits;

      mem_we    = accept && is_pixel && live && !tr;
      mem_waddr = {bank1, newrun ? {IDX_W{1'b0}} : run_len_ff[IDX_W-1:0]};
      mem_wdata = req_tdata;
   end

   always_comb begin
      cap_in     = cap_ff;
      bytes_in   = bytes_ff;
      room_in    = room_ff;
      run_len_in = run_len_ff;
      run_tr_in  = run_tr_ff;
      bank_in    = bank_ff;
      ovf_in     = ovf_ff;
      busy_in    = busy_ff;

      if (free.valid) begin
         busy_in[free.bank] = 1'b0;
      end

      if (csr_we) begin
         cap_in  = csr_wdata;
         room_in = {1'b0, csr_wdata} - {1'b0, bytes_ff};
      end

      if (accept) begin
         if (!is_pixel) begin
            bytes_in   = '0;
            room_in    = {1'b0, cap_ff};
            ovf_in     = 1'b0;
            run_len_in = '0;
            run_tr_in  = 1'b0;
         end else begin
            bytes_in = bytes_ff + CAP_W'(total);
            room_in  = room_ff - (CAP_W + 1)'(total);
            ovf_in   = ovf_new;
            if (ovf_a) begin
               run_len_in = '0;
            end else if (live) begin
               run_len_in = req_tlast ? '0 : len1;
               run_tr_in  = tr1;
               bank_in    = bank1;
            end
            if (a_ok && !run_tr_ff) begin
               busy_in[bank_ff] = 1'b1;
            end
            if (b_ok && !tr1) begin
               busy_in[bank1] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= '1;
         bytes_ff   <= '0;
         room_ff    <= {1'b0, {CAP_W{1'b1}}};
         run_len_ff <= '0;
         run_tr_ff  <= 1'b0;
         bank_ff    <= 1'b0;
         ovf_ff     <= 1'b0;
         busy_ff    <= '0;
      end else begin
         cap_ff     <= cap_in;
         bytes_ff   <= bytes_in;
         room_ff    <= room_in;
         run_len_ff <= run_len_in;
         run_tr_ff  <= run_tr_in;
         bank_ff    <= bank_in;
         ovf_ff     <= ovf_in;
         busy_ff    <= busy_in;
      end
   end

endmodule

// ===== hdl/trle_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// trle_back : byte sequencer and packer
// Walks each queued command one byte per cycle unless stalled, reads the
// literal store and packs bytes four to a result behind an output register.
// ============================================================================
module trle_back import trle_pkg::*; #(
   parameter int RUN_LIMIT = 127
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               head,
   input  logic                  empty,
   output logic                  pop,
   output bank_free_type         free,
   output logic                  mem_re,
   output logic [IDX_W:0]        mem_raddr,
   input  logic [PIX_W-1:0]      mem_rdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int IDX_W = (RUN_LIMIT > 1) ? $clog2(RUN_LIMIT) : 1;

   seq_state_type    st_ff, st_in;
   logic             sel_ff, sel_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   run_desc_type     run;
   logic             last_dat, more_b, run_done, advance, issue_go;

   // token handed from the sequencer to the packer
   logic             tok_valid_ff, tok_valid_in;
   logic [PIX_W-1:0] tok_byte_ff, tok_byte_in;
   logic             tok_ram_ff, tok_ram_in;
   logic             tok_has_ff, tok_has_in;
   logic             tok_end_ff, tok_end_in;
   logic             tok_close_ff, tok_ovf_ff;

   logic [PIX_W-1:0] acc_ff [RSP_BYTES-1];
   logic [1:0]       cnt_ff;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;
   logic                  rsp_last_ff;

   logic [PIX_W-1:0] byte_in;
   logic [PIX_W-1:0] out_b [RSP_BYTES];
   logic [CNT_W-1:0] out_count;
   logic             pack_push, out_free;

   assign run      = sel_ff ? head.run_b : head.run_a;
   assign last_dat = (idx_ff == IDX_W'(run.len - 1'b1));
   assign more_b   = !sel_ff && head.run_b.valid;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign byte_in   = tok_ram_ff ? mem_rdata : tok_byte_ff;
   assign pack_push = tok_valid_ff && (tok_end_ff || (tok_has_ff && (cnt_ff == 2'd3)));
   assign advance   = !(pack_push && !out_free);
   assign issue_go  = advance && (st_ff != SQ_IDLE);

   // next state
   always_comb begin
      st_in  = st_ff;
      sel_in = sel_ff;
      idx_in = idx_ff;
      if (advance) begin
         unique case (st_ff)
            SQ_IDLE: begin
               idx_in = '0;
               if (!empty) begin
                  if (head.run_a.valid) begin
                     st_in  = SQ_HDR;
                     sel_in = 1'b0;
                  end else if (head.run_b.valid) begin
                     st_in  = SQ_HDR;
                     sel_in = 1'b1;
                  end else if (head.zero) begin
                     st_in = SQ_ZERO;
                  end else begin
                     st_in = SQ_EMPTY;
                  end
               end
            end
            SQ_HDR, SQ_DAT: begin
               if (st_ff == SQ_HDR && !run.tr) begin
                  st_in  = SQ_DAT;
                  idx_in = '0;
               end else if (st_ff == SQ_DAT && !last_dat) begin
                  idx_in = idx_ff + 1'b1;
               end else if (more_b) begin
                  st_in  = SQ_HDR;
                  sel_in = 1'b1;
               end else if (head.zero) begin
                  st_in = SQ_ZERO;
               end else begin
                  st_in = SQ_IDLE;
               end
            end
            SQ_ZERO, SQ_EMPTY: begin
               st_in = SQ_IDLE;
            end
            default: begin
               st_in = SQ_IDLE;
            end
         endcase
      end
   end

   // sequencer outputs
   always_comb begin
      tok_valid_in = 1'b0;
      tok_has_in   = 1'b0;
      tok_ram_in   = 1'b0;
      tok_byte_in  = LINE_CLOSE;
      run_done     = 1'b0;
      unique case (st_ff)
         SQ_IDLE: begin
         end
         SQ_HDR: begin
            tok_valid_in = 1'b1;
            tok_has_in   = 1'b1;
            tok_byte_in  = (run.tr ? MARK_TRANSPARENT : MARK_OPAQUE) | {1'b0, run.len};
            run_done     = run.tr;
         end
         SQ_DAT: begin
            tok_valid_in = 1'b1;
            tok_has_in   = 1'b1;
            tok_ram_in   = 1'b1;
            run_done     = last_dat;
         end
         SQ_ZERO: begin
            tok_valid_in = 1'b1;
            tok_has_in   = 1'b1;
         end
         SQ_EMPTY: begin
            tok_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
      tok_end_in = (run_done && !more_b && !head.zero) ||
                   (st_ff == SQ_ZERO) || (st_ff == SQ_EMPTY);
      pop        = issue_go && tok_end_in;
      free.valid = issue_go && (st_ff == SQ_DAT) && last_dat;
      free.bank  = run.bank;
      mem_re     = issue_go && (st_ff == SQ_DAT);
      mem_raddr  = {run.bank, idx_ff};
   end

   // result assembly
   always_comb begin
      for (int j = 0; j < RSP_BYTES - 1; j++) begin
         if (2'(j) < cnt_ff) begin
            out_b[j] = acc_ff[j];
         end else if (2'(j) == cnt_ff && tok_has_ff) begin
            out_b[j] = byte_in;
         end else begin
            out_b[j] = '0;
         end
      end
      out_b[RSP_BYTES-1] = (cnt_ff == 2'd3 && tok_has_ff) ? byte_in : '0;
      out_count = {1'b0, cnt_ff} + {{(CNT_W - 1){1'b0}}, tok_has_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= SQ_IDLE;
         sel_ff       <= 1'b0;
         idx_ff       <= '0;
         tok_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         sel_ff <= sel_in;
         idx_ff <= idx_in;
         if (advance) begin
            tok_valid_ff <= tok_valid_in;
         end
         if (tok_valid_ff && advance) begin
            if (pack_push) begin
               cnt_ff <= '0;
            end else if (tok_has_ff) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         if (tok_valid_ff && pack_push && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tok_byte_ff  <= tok_byte_in;
         tok_ram_ff   <= tok_ram_in;
         tok_has_ff   <= tok_has_in;
         tok_end_ff   <= tok_end_in;
         tok_close_ff <= head.zero;
         tok_ovf_ff   <= head.ovf;
      end
      if (tok_valid_ff && advance && !pack_push && tok_has_ff) begin
         acc_ff[cnt_ff] <= byte_in;
      end
      if (tok_valid_ff && pack_push && out_free) begin
         rsp_data_ff <= {{(RSP_DATA_W - CNT_W - RSP_BYTES * PIX_W){1'b0}}, out_count,
                         out_b[3], out_b[2], out_b[1], out_b[0]};
         rsp_user_ff <= {tok_ovf_ff, tok_end_ff && tok_close_ff};
         rsp_last_ff <= tok_end_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/transparent_run_length_encoder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// transparent_run_length_encoder : 7-bit transparency RLE for palette pixels
// Pixels in, packed run-length bytes out, with a bounded output budget.
// ============================================================================
// A pixel transfer is taken whenever the command queue has room and, for
// the first pixel of a literal run, the literal bank that run will use has
// been read out by the back end. The back end then walks each command one
// output byte at a time, returning to its idle state between commands, and
// results come out four bytes per transfer. Sustained throughput is
// therefore set by the back end's one-byte-per-cycle store read port; with
// short output and no backpressure one pixel per cycle goes in. The literal
// store is two banks of RUN_LIMIT entries (rounded up to a power of two) in
// one RAM; it needs no clearing after reset. Write csr_wdata only while no
// pixel is in flight.
// ============================================================================
module transparent_run_length_encoder import trle_pkg::*; #(
   parameter int RUN_LIMIT = 127    // longest run, 1 to 127
) (
   input  logic                  clock,
   input  logic                  reset,
   // capacity register: bytes allowed since the last restart
   input  logic                  csr_we,
   input  logic [CAP_W-1:0]      csr_wdata,
   // pixel stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // [7:0] pixel
   input  logic [0:0]            req_tuser,   // [0] action (1 = restart)
   input  logic                  req_tlast,   // line_end
   // packed byte stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] byte0, [15:8] byte1,
                                              // [23:16] byte2, [31:24] byte3,
                                              // [34:32] byte_count, rest 0
   output logic [RSP_USER_W-1:0] rsp_tuser,   // [0] line_done, [1] overflow
   output logic                  rsp_tlast    // last result of the pixel
);

   localparam int IDX_W   = (RUN_LIMIT > 1) ? $clog2(RUN_LIMIT) : 1;
   localparam int RAM_D   = 2 ** (IDX_W + 1);
   localparam int CNT_LSB = RSP_BYTES * PIX_W;
   localparam int LD_BIT  = 0;
   localparam int OVF_BIT = 1;

   cmd_type          cmd, head;
   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   bank_free_type    free;
   logic             mem_we, mem_re;
   logic [IDX_W:0]   mem_waddr, mem_raddr;
   logic [PIX_W-1:0] mem_wdata, mem_rdata;

   // Front end: run tracking, budget checks, literal writes.
   trle_front #(.RUN_LIMIT(RUN_LIMIT)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser[0]),
      .req_tlast  (req_tlast),
      .cmd_push   (cmd_push),
      .cmd        (cmd),
      .cmd_full   (cmd_full),
      .free       (free),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata)
   );

   // One command per pixel that produces any result.
   trle_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head      (head),
      .empty     (cmd_empty)
   );

   // Literal store, ping-pong banks selected by the address MSB.
   trle_ram #(.WIDTH(PIX_W), .DEPTH(RAM_D)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Back end: byte sequencing, packing, output register.
   trle_back #(.RUN_LIMIT(RUN_LIMIT)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (cmd_empty),
      .pop        (cmd_pop),
      .free       (free),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Only the final result of a pixel may be short.
   a_full_unless_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[CNT_LSB +: CNT_W] == CNT_W'(RSP_BYTES))
      else $error("non-final result carries fewer than four bytes");

   // An empty result only reports a sticky overflow.
   a_empty_is_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[CNT_LSB +: CNT_W] == '0 |-> rsp_tuser[OVF_BIT] && rsp_tlast)
      else $error("empty result without overflow");

   // The closing byte is always in the pixel's final result.
   a_line_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[LD_BIT] |-> rsp_tlast)
      else $error("line_done on a non-final result");

   // Front end never writes the bank the back end is reading.
   a_bank_conflict: assert property (@(posedge clock) disable iff (reset)
      mem_we && mem_re |-> mem_waddr[IDX_W] != mem_raddr[IDX_W])
      else $error("literal write into a bank under readout");

endmodule

// ===== bench/tb_transparent_run_length_encoder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_transparent_run_length_encoder : self-checking bench for the RLE encoder
// Drives pixel lines through the stream port under varied flow control and
// output budgets. Every result transfer is compared field by field against a
// bit-exact software encoder kept inside the bench.
// ============================================================================
module tb_transparent_run_length_encoder;
   import trle_pkg::*;

   localparam int               RUN_MAX        = 127;      // DUT RUN_LIMIT
   localparam logic [CAP_W-1:0] CAP_MAX        = 24'hFFFFFF;
   localparam int               SETTLE_CYCLES  = 40;       // after last result
   localparam int               HOLD_CYCLES    = 400;      // long rsp hold-off
   localparam int               WATCHDOG_LIMIT = 5000;     // cycles w/o transfer
   localparam int               PHASE_ITEMS    = 110;      // random items/phase

   // one expected result transfer
   typedef struct packed {
      logic [RSP_BYTES-1:0][PIX_W-1:0] bytes;
      logic [CNT_W-1:0]                count;
      logic                            line_done;
      logic                            ovf;
      logic                            last;
   } rle_word_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CAP_W-1:0]      csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata;    // [7:0] pixel
   logic [0:0]            req_tuser;    // [0] action
   logic                  req_tlast;    // line_end
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;    // [31:0] byte0..byte3, [34:32] byte_count
   logic [RSP_USER_W-1:0] rsp_tuser;    // [0] line_done, [1] overflow
   logic                  rsp_tlast;

   // flow control knobs, set by the test sequence
   int  send_idle_pct;
   int  recv_stall_pct;
   logic hold_go;
   int  hold_left;

   // encoder shadow state
   logic [CAP_W-1:0] cap_q;
   logic [PIX_W-1:0] lit_mem [0:RUN_MAX-1];
   int unsigned      run_len;
   bit               run_clear;      // pending run is transparent
   int unsigned      bytes_out;
   bit               ovf_flag;
   logic [PIX_W-1:0] pend_buf [$];
   rle_word_t        encoded_words [$];

   // bookkeeping
   int mismatches;
   int items_sent;
   int words_checked;
   int cap_writes;
   int overflow_words;
   int stuck_cycles;

   transparent_run_length_encoder #(
      .RUN_LIMIT (RUN_MAX)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Shadow encoder
   // ------------------------------------------------------------------------

   // Reserve n output bytes against the budget; on failure the pending run
   // is dropped and overflow sticks until restart.
   function automatic bit claim_bytes(input int unsigned n);
      if (ovf_flag || bytes_out + n > cap_q) begin
         ovf_flag = 1'b1;
         run_len  = 0;
         return 1'b0;
      end
      bytes_out = (bytes_out + n) & CAP_MAX;
      return 1'b1;
   endfunction

   task automatic flush_run();
      int unsigned i;
      if (run_len == 0 || ovf_flag)
         return;
      if (run_clear) begin
         if (claim_bytes(1))
            pend_buf.push_back(MARK_TRANSPARENT | {1'b0, run_len[LEN_W-1:0]});
      end else if (claim_bytes(1 + run_len)) begin
         pend_buf.push_back(MARK_OPAQUE | {1'b0, run_len[LEN_W-1:0]});
         for (i = 0; i < run_len; i++)
            pend_buf.push_back(lit_mem[i]);
      end
      run_len = 0;
   endtask

   // Work out the result transfers one accepted pixel transfer causes.
   task automatic encode_pixel(input logic act, input logic [PIX_W-1:0] pix,
                               input logic line_end);
      bit        clear_px;
      bit        closed;
      int        nres;
      int        cnt;
      int        k;
      int        j;
      rle_word_t w;
      clear_px = (pix == '0);
      closed   = 1'b0;
      if (act == ACT_RESTART) begin
         bytes_out = 0;
         ovf_flag  = 1'b0;
         run_len   = 0;
         run_clear = 1'b0;
         return;
      end
      pend_buf.delete();
      if (!ovf_flag) begin
         // kind change or full run closes the pending run first
         if (run_len > 0 && (clear_px != run_clear || run_len >= RUN_MAX))
            flush_run();
         if (!ovf_flag) begin
            if (run_len == 0)
               run_clear = clear_px;
            if (!clear_px && run_len < RUN_MAX)
               lit_mem[run_len] = pix;
            if (run_len < RUN_MAX)
               run_len++;
         end
         if (line_end && !ovf_flag) begin
            flush_run();
            if (!ovf_flag && claim_bytes(1)) begin
               pend_buf.push_back(LINE_CLOSE);
               closed = 1'b1;
            end
         end
      end
      if (pend_buf.size() == 0) begin
         // sticky overflow still answers every pixel
         if (ovf_flag) begin
            w      = '0;
            w.ovf  = 1'b1;
            w.last = 1'b1;
            encoded_words.push_back(w);
         end
         return;
      end
      nres = (pend_buf.size() + 3) / 4;
      for (k = 0; k < nres; k++) begin
         w   = '0;
         cnt = pend_buf.size() - k * RSP_BYTES;
         if (cnt > RSP_BYTES)
            cnt = RSP_BYTES;
         for (j = 0; j < cnt; j++)
            w.bytes[j] = pend_buf[k * RSP_BYTES + j];
         w.count     = CNT_W'(cnt);
         w.line_done = closed && (k == nres - 1);
         w.ovf       = ovf_flag;
         w.last      = (k == nres - 1);
         encoded_words.push_back(w);
      end
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [RSP_DATA_W-1:0] got,
                                  input logic [RSP_DATA_W-1:0] want);
      $display("[%0t] mismatch on %s: got %0h, want %0h (result %0d)",
               $realtime, what, got, want, words_checked);
      mismatches++;
   endtask

   task automatic check_word();
      rle_word_t e;
      int        j;
      if (encoded_words.size() == 0) begin
         report_mismatch("unexpected result", rsp_tdata, '0);
         return;
      end
      e = encoded_words.pop_front();
      for (j = 0; j < RSP_BYTES; j++)
         if (rsp_tdata[PIX_W*j +: PIX_W] !== e.bytes[j])
            report_mismatch($sformatf("byte%0d", j), rsp_tdata[PIX_W*j +: PIX_W],
                            e.bytes[j]);
      if (rsp_tdata[RSP_BYTES*PIX_W +: CNT_W] !== e.count)
         report_mismatch("byte_count", rsp_tdata[RSP_BYTES*PIX_W +: CNT_W], e.count);
      if (rsp_tuser[0] !== e.line_done)
         report_mismatch("line_done", rsp_tuser[0], e.line_done);
      if (rsp_tuser[1] !== e.ovf)
         report_mismatch("overflow", rsp_tuser[1], e.ovf);
      if (rsp_tlast !== e.last)
         report_mismatch("last", rsp_tlast, e.last);
      if (e.ovf)
         overflow_words++;
      words_checked++;
   endtask

   // Monitor: register writes, input transfers and result transfers are all
   // taken at the same edge, in that order, so prediction always precedes
   // any result it may cause. Also runs the no-progress watchdog.
   always @(posedge clock) begin
      if (reset) begin
         cap_q        = CAP_MAX;
         run_len      = 0;
         run_clear    = 1'b0;
         bytes_out    = 0;
         ovf_flag     = 1'b0;
         stuck_cycles = 0;
         encoded_words.delete();
      end else begin
         if (csr_we) begin
            cap_q = csr_wdata;
            cap_writes++;
         end
         if (req_tvalid && req_tready)
            encode_pixel(req_tuser[0], req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            check_word();
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] timeout: no transfer for %0d cycles", $realtime,
                     WATCHDOG_LIMIT);
            $display("tb_transparent_run_length_encoder failed");
            $finish;
         end
      end
   end

   // Result side: random stalls, plus a long hold-off counted here when
   // hold_go is pulsed.
   always @(posedge clock) begin
      if (hold_go) begin
         hold_left  <= HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------

   // One pixel-side transfer. tvalid stays high on return so back-to-back
   // items need no bubble; any task that waits lowers it first.
   task automatic send_pixel(input logic act, input logic [PIX_W-1:0] pix,
                             input logic line_end);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= pix;
      req_tlast  <= line_end;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      items_sent++;
   endtask

   // Stop offering, wait for every expected result, then let the block settle.
   // The queue is sampled at the falling edge, clear of the monitor's update.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (encoded_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_W-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic send_noise();
      send_pixel(($urandom_range(99) < 25) ? ACT_RESTART : ACT_PIXEL,
                 PIX_W'($urandom), 1'($urandom));
   endtask

   // A well-formed line: a few runs of random kind and length, line end on
   // the last pixel, with occasional stray items mixed in.
   task automatic send_random_line();
      int   nruns;
      int   len;
      int   r;
      int   i;
      int   j;
      logic clear_run;
      nruns = $urandom_range(6, 1);
      for (i = 0; i < nruns; i++) begin
         r = $urandom_range(99);
         if (r < 85)
            len = $urandom_range(8, 1);
         else if (r < 97)
            len = $urandom_range(40, 9);
         else
            len = $urandom_range(140, 100);
         clear_run = 1'($urandom);
         for (j = 0; j < len; j++) begin
            if ($urandom_range(99) < 6)
               send_noise();
            send_pixel(ACT_PIXEL, clear_run ? '0 : PIX_W'($urandom_range(255, 1)),
                       (i == nruns - 1) && (j == len - 1));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   task automatic test_directed();
      set_capacity(CAP_MAX);
      send_pixel(ACT_PIXEL, 8'h00, 1'b1);     // lone transparent pixel line
      send_pixel(ACT_PIXEL, 8'hFF, 1'b1);     // lone literal line
      send_pixel(ACT_PIXEL, 8'h01, 1'b0);
      send_pixel(ACT_PIXEL, 8'h00, 1'b0);     // kind change closes literal run
      send_pixel(ACT_PIXEL, 8'h00, 1'b0);
      send_pixel(ACT_PIXEL, 8'h80, 1'b0);
      send_pixel(ACT_PIXEL, 8'h00, 1'b1);     // line end on a kind change
      send_pixel(ACT_RESTART, 8'hFF, 1'b1);   // restart ignores pixel fields
      // one byte of budget: run fits, closing byte overflows
      set_capacity(24'd1);
      send_pixel(ACT_PIXEL, 8'h00, 1'b1);
      send_pixel(ACT_PIXEL, 8'h7F, 1'b1);     // sticky overflow
      send_pixel(ACT_PIXEL, 8'h00, 1'b0);
      send_pixel(ACT_RESTART, 8'h00, 1'b0);
      send_pixel(ACT_PIXEL, 8'h42, 1'b1);     // literal run too big outright
      send_pixel(ACT_RESTART, 8'h00, 1'b0);
      // literal run fits exactly, closing byte does not
      set_capacity(24'd3);
      send_pixel(ACT_PIXEL, 8'h09, 1'b0);
      send_pixel(ACT_PIXEL, 8'h09, 1'b1);
      send_pixel(ACT_RESTART, 8'h00, 1'b0);
      // budget lowered below what was already written
      set_capacity(CAP_MAX);
      send_pixel(ACT_PIXEL, 8'h33, 1'b0);
      send_pixel(ACT_PIXEL, 8'h44, 1'b1);
      set_capacity(24'd2);
      send_pixel(ACT_PIXEL, 8'h00, 1'b1);
      send_pixel(ACT_RESTART, 8'h00, 1'b0);
      send_pixel(ACT_PIXEL, 8'h00, 1'b1);     // fits exactly after restart
      wait_drained();
   endtask

   // Runs at the length limit: a full transparent run closed by the line end,
   // and a full literal run broken by one more pixel (largest burst).
   task automatic test_run_limit();
      int i;
      set_capacity(CAP_MAX);
      send_pixel(ACT_RESTART, 8'h00, 1'b0);
      for (i = 0; i < RUN_MAX; i++)
         send_pixel(ACT_PIXEL, 8'h00, i == RUN_MAX - 1);
      for (i = 0; i <= RUN_MAX; i++)
         send_pixel(ACT_PIXEL, PIX_W'($urandom_range(255, 1)), i == RUN_MAX);
      wait_drained();
   endtask

   task automatic test_random_flow(input int idle_pct, input int stall_pct,
                                   input logic [CAP_W-1:0] cap);
      int start;
      set_capacity(cap);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      send_pixel(ACT_RESTART, 8'h00, 1'b0);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS)
         send_random_line();
      wait_drained();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   // Result side held off while pixels keep coming: the block must fill and
   // push back on its input without losing anything.
   task automatic test_hold_off();
      int i;
      set_capacity(CAP_MAX);
      send_pixel(ACT_RESTART, 8'h00, 1'b0);
      req_tvalid <= 1'b0;
      hold_go    <= 1'b1;
      @(posedge clock);
      hold_go    <= 1'b0;
      for (i = 0; i < 40; i++)
         send_pixel(ACT_PIXEL, (i % 3 == 0) ? '0 : PIX_W'($urandom_range(255, 1)),
                    (i % 7 == 6));
      wait_drained();
   endtask

   // Sender pauses mid-line until everything is out, then finishes the line.
   task automatic test_drain_pause();
      send_idle_pct  = 37;
      recv_stall_pct = 37;
      send_random_line();
      send_pixel(ACT_PIXEL, 8'h21, 1'b0);
      send_pixel(ACT_PIXEL, 8'h00, 1'b0);
      wait_drained();
      send_pixel(ACT_PIXEL, 8'h00, 1'b0);
      send_pixel(ACT_PIXEL, 8'hC3, 1'b1);
      send_random_line();
      wait_drained();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      req_tvalid     <= 1'b0;
      req_tdata      <= '0;
      req_tuser      <= '0;
      req_tlast      <= 1'b0;
      hold_go        <= 1'b0;
      hold_left      = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      mismatches     = 0;
      items_sent     = 0;
      words_checked  = 0;
      cap_writes     = 0;
      overflow_words = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_run_limit();
      test_random_flow(0, 0, CAP_MAX);
      test_random_flow(78, 0, 24'($urandom_range(2000, 200)));
      test_random_flow(0, 78, 24'd1);
      test_random_flow(37, 37, 24'($urandom_range(24'hFFFFFF, 1)));
      test_hold_off();
      test_drain_pause();

      wait_drained();
      repeat (200) @(posedge clock);
      if (encoded_words.size() != 0)
         report_mismatch("results never delivered", encoded_words.size(), '0);

      $display("run covered %0d pixel transfers, %0d result transfers (%0d flagged overflow),",
               items_sent, words_checked, overflow_words);
      $display("%0d capacity writes, four flow-control mixes and a long output hold-off",
               cap_writes);
      if (mismatches == 0)
         $display("tb_transparent_run_length_encoder passed");
      else
         $display("tb_transparent_run_length_encoder failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/trle_pkg.sv
hdl/trle_ram.sv
hdl/trle_cmd_fifo.sv
hdl/trle_front.sv
hdl/trle_back.sv
hdl/transparent_run_length_encoder.sv
bench/tb_transparent_run_length_encoder.sv
